/* rtl/mria_pkg.sv */
// Shared types, constants and microcode program of the mixed-radix index adder.
package mria_pkg;

  localparam int NUM_RADIX = 8;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 16;
  localparam int RADIX_W = 16;
  localparam int PORT_DIGIT_W = 16;
  localparam int AMOUNT_W = 32;
  localparam int SEL_W = 3;
  localparam int PC_W = 4;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_WRITE,
    OP_LOAD,
    OP_READ_PTR,
    OP_DIV_LOAD,
    OP_DIV_STEP,
    OP_STORE,
    OP_EMIT_INIT,
    OP_READ_K,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NO_IN,
    C_CMD_ADD,
    C_STOP,
    C_DIV_MORE,
    C_OUT_BUSY,
    C_K_MORE
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [PC_W-1:0]  target;
  } uword_t;

  typedef struct packed {
    logic no_in;
    logic cmd_add;
    logic stop;
    logic div_more;
    logic out_busy;
    logic k_more;
  } flags_t;

  localparam logic [PC_W-1:0] S_IDLE      = 4'd0;
  localparam logic [PC_W-1:0] S_DISPATCH  = 4'd1;
  localparam logic [PC_W-1:0] S_WRITE     = 4'd2;
  localparam logic [PC_W-1:0] S_ADD_INIT  = 4'd3;
  localparam logic [PC_W-1:0] S_TEST      = 4'd4;
  localparam logic [PC_W-1:0] S_DIV_LOAD  = 4'd5;
  localparam logic [PC_W-1:0] S_DIV_STEP  = 4'd6;
  localparam logic [PC_W-1:0] S_STORE     = 4'd7;
  localparam logic [PC_W-1:0] S_EMIT_INIT = 4'd8;
  localparam logic [PC_W-1:0] S_EMIT_READ = 4'd9;
  localparam logic [PC_W-1:0] S_EMIT      = 4'd10;
  localparam logic [PC_W-1:0] S_EMIT_NEXT = 4'd11;
  localparam logic [PC_W-1:0] S_DONE      = 4'd12;

  // Taken jump goes to target, otherwise pc + 1.
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{op: OP_NONE, cond: C_ALWAYS, target: S_IDLE};
    case (pc)
      S_IDLE:      w = '{op: OP_ACCEPT,    cond: C_NO_IN,    target: S_IDLE};
      S_DISPATCH:  w = '{op: OP_NONE,      cond: C_CMD_ADD,  target: S_ADD_INIT};
      S_WRITE:     w = '{op: OP_WRITE,     cond: C_ALWAYS,   target: S_IDLE};
      S_ADD_INIT:  w = '{op: OP_LOAD,      cond: C_ALWAYS,   target: S_TEST};
      S_TEST:      w = '{op: OP_READ_PTR,  cond: C_STOP,     target: S_EMIT_INIT};
      S_DIV_LOAD:  w = '{op: OP_DIV_LOAD,  cond: C_ALWAYS,   target: S_DIV_STEP};
      S_DIV_STEP:  w = '{op: OP_DIV_STEP,  cond: C_DIV_MORE, target: S_DIV_STEP};
      S_STORE:     w = '{op: OP_STORE,     cond: C_ALWAYS,   target: S_TEST};
      S_EMIT_INIT: w = '{op: OP_EMIT_INIT, cond: C_ALWAYS,   target: S_EMIT_READ};
      S_EMIT_READ: w = '{op: OP_READ_K,    cond: C_ALWAYS,   target: S_EMIT};
      S_EMIT:      w = '{op: OP_EMIT,      cond: C_OUT_BUSY, target: S_EMIT};
      S_EMIT_NEXT: w = '{op: OP_NONE,      cond: C_K_MORE,   target: S_EMIT_READ};
      S_DONE:      w = '{op: OP_NONE,      cond: C_ALWAYS,   target: S_IDLE};
      default:     w = '{op: OP_NONE,      cond: C_ALWAYS,   target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* rtl/mria_seq.sv */
// Microcode sequencer: step counter, control store and conditional jumps.
module mria_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mria_pkg::flags_t flags_i,
  output mria_pkg::op_e   op_o
);
  import mria_pkg::*;

  logic [PC_W-1:0] pc_q, pc_d;
  uword_t          uw;
  logic            take;

  assign uw   = ucode(pc_q);
  assign op_o = uw.op;

  always_comb begin
    case (uw.cond)
      C_ALWAYS:   take = 1'b1;
      C_NO_IN:    take = flags_i.no_in;
      C_CMD_ADD:  take = flags_i.cmd_add;
      C_STOP:     take = flags_i.stop;
      C_DIV_MORE: take = flags_i.div_more;
      C_OUT_BUSY: take = flags_i.out_busy;
      C_K_MORE:   take = flags_i.k_more;
      default:    take = 1'b1;
    endcase
  end

  always_comb begin
    pc_d = take ? uw.target : pc_q + PC_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= S_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

/* rtl/mria_div.sv */
// Restoring divider, one quotient bit per cycle while step_i is high.
module mria_div #(
  parameter int CW = 36,
  parameter int RW = 17
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          step_i,
  input  logic [CW-1:0] dividend_i,
  input  logic [RW-1:0] divisor_i,
  output logic [CW-1:0] quo_o,
  output logic [RW-1:0] rem_o,
  output logic          more_o
);
  localparam int CNTW = $clog2(CW + 1);

  logic [CW-1:0]   quo_q, quo_d;
  logic [RW-1:0]   rem_q, rem_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [RW:0]     trial, diff;
  logic            ge;

  assign trial = {rem_q, quo_q[CW-1]};
  assign ge    = trial >= {1'b0, divisor_i};
  assign diff  = trial - {1'b0, divisor_i};

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      cnt_d = CNTW'(CW);
    end else if (step_i) begin
      quo_d = {quo_q[CW-2:0], ge};
      rem_d = ge ? diff[RW-1:0] : trial[RW-1:0];
      cnt_d = cnt_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
  assign more_o = cnt_q != CNTW'(1);

endmodule

/* rtl/mria_store.sv */
// Digit memory with per-entry valid bits; unwritten entries read as zero.
module mria_store #(
  parameter int DEPTH = 4,
  parameter int DW    = 16,
  parameter int AW    = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);
  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [DW-1:0]    rdata_q;
  logic             rvld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvld_q <= vld_q[raddr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

/* rtl/mixed_radix_index_adder.sv */
// Top level: mixed-radix index adder with microcoded control.
// Keeps a DIGITS-digit index, digit 0 most significant, each digit with its own
// radix register (0 means 2^DIGIT_BITS). A write item (cmd 1) gives no result. An
// add item (cmd 0) runs, for each of the n digits the carry reaches, the shared
// restoring divider, one quotient bit per cycle over a 36-bit dividend, plus 3
// control steps; the digits then leave one at a time through the single read
// port of the digit memory: each is read in S_EMIT_READ, sent in S_EMIT while the
// output does not stall, and counted on in S_EMIT_NEXT.
// Every add gives DIGITS result items, digit 0 first, last set on the final one.
module mixed_radix_index_adder #(
  parameter int DIGITS     = 4,
  parameter int DIGIT_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [mria_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [mria_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 cmd_i,
  input  logic [mria_pkg::AMOUNT_W-1:0]        add_amount_i,
  input  logic [mria_pkg::SEL_W-1:0]           digit_select_i,
  input  logic [mria_pkg::PORT_DIGIT_W-1:0]    digit_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [mria_pkg::SEL_W-1:0]           digit_number_o,
  output logic [mria_pkg::PORT_DIGIT_W-1:0]    digit_value_o,
  output logic [mria_pkg::AMOUNT_W-1:0]        carry_out_o,
  output logic                                 last_o
);
  import mria_pkg::*;

  localparam int CW = ((DIGIT_BITS > AMOUNT_W) ? DIGIT_BITS : AMOUNT_W) + 4;
  localparam int RW = ((DIGIT_BITS + 1) > RADIX_W) ? (DIGIT_BITS + 1) : RADIX_W;
  localparam int AW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int KW = $clog2(DIGITS + 1);

  op_e    op;
  flags_t flags;

  logic [RADIX_W-1:0] radix_q [NUM_RADIX];

  logic                    cmd_q;
  logic [AMOUNT_W-1:0]     amt_q;
  logic [SEL_W-1:0]        sel_q;
  logic [PORT_DIGIT_W-1:0] data_q;

  logic [CW-1:0]       carry_q;
  logic [AW-1:0]       ptr_q;
  logic [KW-1:0]       left_q;
  logic [KW-1:0]       k_q;
  logic [AMOUNT_W-1:0] cout_q;

  logic                    out_valid_q;
  logic [SEL_W-1:0]        out_num_q;
  logic [PORT_DIGIT_W-1:0] out_val_q;
  logic [AMOUNT_W-1:0]     out_cout_q;
  logic                    out_last_q;

  logic [RADIX_W-1:0]          rsel_raw;
  logic [RW-1:0]               radix_sel;
  logic [CW-1:0]               quo;
  logic [RW-1:0]               rem;
  logic                        div_more;
  logic                        sel_ok;
  logic                        st_we, st_re;
  logic [AW-1:0]               st_waddr, st_raddr;
  logic [DIGIT_BITS-1:0]       st_wdata, st_rdata;
  logic [DIGIT_BITS+15:0]      wr_ext, rd_ext;
  logic                        out_free;
  logic [AMOUNT_W-1:0]         cout_sat;

  mria_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .op_o    (op)
  );

  mria_div #(.CW(CW), .RW(RW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (op == OP_DIV_LOAD),
    .step_i     (op == OP_DIV_STEP),
    .dividend_i (carry_q + CW'(st_rdata)),
    .divisor_i  (radix_sel),
    .quo_o      (quo),
    .rem_o      (rem),
    .more_o     (div_more)
  );

  mria_store #(.DEPTH(DIGITS), .DW(DIGIT_BITS), .AW(AW)) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  assign rsel_raw  = radix_q[SEL_W'(ptr_q)];
  assign radix_sel = (rsel_raw == '0) ? (RW'(1) << DIGIT_BITS) : RW'(rsel_raw);

  assign sel_ok   = {1'b0, sel_q} < (SEL_W + 1)'(DIGITS);
  assign wr_ext   = {DIGIT_BITS'(0), data_q};
  assign rd_ext   = {16'(0), st_rdata};
  assign st_we    = (op == OP_STORE) || ((op == OP_WRITE) && sel_ok);
  assign st_waddr = (op == OP_WRITE) ? sel_q[AW-1:0] : ptr_q;
  assign st_wdata = (op == OP_WRITE) ? wr_ext[DIGIT_BITS-1:0] : rem[DIGIT_BITS-1:0];
  assign st_re    = (op == OP_READ_PTR) || (op == OP_READ_K);
  assign st_raddr = (op == OP_READ_K) ? k_q[AW-1:0] : ptr_q;

  assign out_free = !out_valid_q || !out_stall_i;
  assign cout_sat = (carry_q[CW-1:AMOUNT_W] != '0) ? '1 : carry_q[AMOUNT_W-1:0];

  assign flags.no_in    = !in_valid_i;
  assign flags.cmd_add  = cmd_q == CMD_ADD;
  assign flags.stop     = (carry_q == '0) || (left_q == '0);
  assign flags.div_more = div_more;
  assign flags.out_busy = !out_free;
  assign flags.k_more   = k_q != KW'(DIGITS);

  assign in_stall_o = op != OP_ACCEPT;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_RADIX; i++) begin
        radix_q[i] <= RADIX_W'(10);
      end
    end else if (cfg_we_i && !cfg_idx_i[CFG_IDX_W-1]) begin
      radix_q[cfg_idx_i[SEL_W-1:0]] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op == OP_ACCEPT && in_valid_i) begin
      cmd_q  <= cmd_i;
      amt_q  <= add_amount_i;
      sel_q  <= digit_select_i;
      data_q <= digit_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= '0;
      ptr_q   <= '0;
      left_q  <= '0;
      k_q     <= '0;
    end else begin
      case (op)
        OP_LOAD: begin
          carry_q <= CW'(amt_q);
          ptr_q   <= AW'(DIGITS - 1);
          left_q  <= KW'(DIGITS);
        end
        OP_STORE: begin
          carry_q <= quo;
          ptr_q   <= ptr_q - AW'(1);
          left_q  <= left_q - KW'(1);
        end
        OP_EMIT_INIT: begin
          k_q <= '0;
        end
        OP_EMIT: begin
          if (out_free) begin
            k_q <= k_q + KW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (op == OP_EMIT_INIT) begin
      cout_q <= cout_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (op == OP_EMIT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op == OP_EMIT && out_free) begin
      out_num_q  <= SEL_W'(k_q);
      out_val_q  <= rd_ext[PORT_DIGIT_W-1:0];
      out_cout_q <= cout_q;
      out_last_q <= k_q == KW'(DIGITS - 1);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign digit_number_o = out_num_q;
  assign digit_value_o  = out_val_q;
  assign carry_out_o    = out_cout_q;
  assign last_o         = out_last_q;

  a_rem_below_radix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op == OP_STORE) |-> (rem < radix_sel))
    else $error("remainder not below radix at digit store");

  a_cout_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op == OP_EMIT_INIT) |=>
      ((cout_q == '1) || (cout_q == $past(carry_q[AMOUNT_W-1:0]))))
    else $error("carry out does not match final carry");

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> ((SEL_W + 1)'(digit_number_o) == (SEL_W + 1)'(DIGITS - 1)))
    else $error("last flag on a digit other than the final one");

endmodule
